### rtl/nfam_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the NOR flash array model.
package nfam_pkg;

    localparam int ARRAY_BYTES = 65536;
    localparam int ADDR_W      = $clog2(ARRAY_BYTES);
    localparam int SIZE_W      = ADDR_W + 1;

    localparam logic [7:0]        ERASED_BYTE = 8'hFF;
    localparam logic [SIZE_W-1:0] ARRAY_SIZE  = SIZE_W'(ARRAY_BYTES);

    typedef enum logic [2:0] {
        CMD_READ         = 3'd0,
        CMD_WRITE_AND    = 3'd1,
        CMD_PROGRAM      = 3'd2,
        CMD_ERASE_SECTOR = 3'd3,
        CMD_ERASE_BLOCK  = 3'd4,
        CMD_ERASE_RANGE  = 3'd5,
        CMD_ERASE_CHIP   = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ADDR  = 2'd1,
        ST_NOT_BLANK = 2'd2,
        ST_MISMATCH  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_MEM_SIZE     = 2'd0,
        REG_SECTOR_BYTES = 2'd1,
        REG_BLOCK_BYTES  = 2'd2,
        REG_NONE         = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ERASE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_in;
        logic [SIZE_W-1:0] length;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

endpackage

### rtl/nfam_cell_ram.sv
`timescale 1ns / 1ps
// Byte-wide cell array: one write or read address per cycle, registered read data.
module nfam_cell_ram
    import nfam_pkg::*;
(
    input  logic       i_clk,
    input  t_ram_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [ARRAY_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/nor_flash_array_model_unit.sv
`timescale 1ns / 1ps
// Top level of the NOR flash array model: command sequencer, registers and output stage.
// Read, write and program: the accepted word goes through S_EXEC, which reads the old cell
//   value and, for write and program, writes the cell, then S_DONE, which loads the output
//   register; no new word is taken until the state is back in S_IDLE. Erases walk the clipped
//   region in S_ERASE between S_EXEC and S_DONE (skipped for an empty region); one cell written
//   per cycle. S_DONE holds while the output register still waits for i_out_ready.
// Reset is synchronous, active low; afterwards a clearing pass writes 0xFF to all
//   ARRAY_BYTES cells before the first word is taken; config writes work.
module nor_flash_array_model_unit
    import nfam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] r_mem_size;
    logic [SIZE_W-1:0] r_sector_bytes;
    logic [SIZE_W-1:0] r_block_bytes;
    t_reg_idx          reg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size     <= ARRAY_SIZE;
            r_sector_bytes <= SIZE_W'(4096);
            r_block_bytes  <= ARRAY_SIZE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MEM_SIZE:     r_mem_size     <= pwdata[SIZE_W-1:0];
                REG_SECTOR_BYTES: r_sector_bytes <= pwdata[SIZE_W-1:0];
                REG_BLOCK_BYTES:  r_block_bytes  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_MEM_SIZE:     prdata[SIZE_W-1:0] = r_mem_size;
            REG_SECTOR_BYTES: prdata[SIZE_W-1:0] = r_sector_bytes;
            REG_BLOCK_BYTES:  prdata[SIZE_W-1:0] = r_block_bytes;
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Cell RAM
    // ---------------------------------------------------------------
    t_ram_req   ram_req;
    logic [7:0] ram_rdata;

    nfam_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_state            r_state,     n_state;
    t_in_word          r_cur,       n_cur;
    logic [SIZE_W-1:0] r_ptr,       n_ptr;
    logic [SIZE_W-1:0] r_end,       n_end;
    t_out_word         r_res,       n_res;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out,       n_out;

    logic [SIZE_W-1:0] limit;
    logic [SIZE_W-1:0] cur_addr;
    logic [SIZE_W-1:0] room;
    logic [SIZE_W-1:0] count;
    logic [SIZE_W-1:0] ptr_inc;
    logic [7:0]        and_val;
    logic              slot_free;
    t_cmd              cmd;

    // Size in use is the smaller of the register and the physical array.
    assign limit     = (r_mem_size > ARRAY_SIZE) ? ARRAY_SIZE : r_mem_size;
    assign cur_addr  = {1'b0, r_cur.address};
    assign room      = limit - cur_addr;
    assign ptr_inc   = r_ptr + SIZE_W'(1);
    assign and_val   = ram_rdata & r_cur.data_in;
    assign cmd       = t_cmd'(r_cur.command);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (cmd)
            CMD_ERASE_SECTOR: count = r_sector_bytes;
            CMD_ERASE_BLOCK:  count = r_block_bytes;
            default:          count = r_cur.length;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        ram_req     = '{we: 1'b0, addr: r_cur.address, wdata: ERASED_BYTE};

        // drop the held result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // wipe every physical cell after reset
                ram_req = '{we: 1'b1, addr: r_ptr[ADDR_W-1:0], wdata: ERASED_BYTE};
                n_ptr   = ptr_inc;
                if (ptr_inc == r_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // read the addressed cell while taking the word
                o_in_ready   = 1'b1;
                ram_req.addr = i_in.address;
                if (i_in_valid) begin
                    n_cur   = i_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // old cell value is on ram_rdata now
                n_state = S_DONE;
                if (cmd == CMD_ERASE_CHIP) begin
                    n_res = '{read_data: ERASED_BYTE, status: ST_OK};
                    n_ptr = '0;
                    n_end = limit;
                    if (limit != '0) begin
                        n_state = S_ERASE;
                    end
                end else if (cur_addr >= limit) begin
                    n_res = '{read_data: 8'h00, status: ST_BAD_ADDR};
                end else begin
                    unique case (cmd)
                        CMD_WRITE_AND: begin
                            ram_req.we    = 1'b1;
                            ram_req.wdata = and_val;
                            n_res.read_data = and_val;
                            n_res.status    = (and_val != r_cur.data_in) ? ST_MISMATCH
                                                                         : ST_OK;
                        end
                        CMD_PROGRAM: begin
                            if (ram_rdata != ERASED_BYTE) begin
                                n_res = '{read_data: ram_rdata, status: ST_NOT_BLANK};
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.wdata = r_cur.data_in;
                                n_res = '{read_data: r_cur.data_in, status: ST_OK};
                            end
                        end
                        CMD_ERASE_SECTOR, CMD_ERASE_BLOCK, CMD_ERASE_RANGE: begin
                            // clip the region at the size in use
                            n_ptr = cur_addr;
                            n_end = (count > room) ? limit : cur_addr + count;
                            if (count == '0) begin
                                n_res = '{read_data: ram_rdata, status: ST_OK};
                            end else begin
                                n_res   = '{read_data: ERASED_BYTE, status: ST_OK};
                                n_state = S_ERASE;
                            end
                        end
                        default: begin
                            // read, and the unused code seven
                            n_res = '{read_data: ram_rdata, status: ST_OK};
                        end
                    endcase
                end
            end
            S_ERASE: begin
                ram_req = '{we: 1'b1, addr: r_ptr[ADDR_W-1:0], wdata: ERASED_BYTE};
                n_ptr   = ptr_inc;
                if (ptr_inc == r_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_end       <= ARRAY_SIZE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted word did not enter execution");

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE || r_state == S_CLEAR) |-> (r_ptr < r_end))
        else $error("erase pointer outside its region");

    a_walk_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE) |-> (ram_req.we && ram_req.wdata == ERASED_BYTE))
        else $error("erase walk not writing erased bytes");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("word taken while busy");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && slot_free) |=> o_out_valid)
        else $error("finished result not presented");

endmodule
